@@ rtl/pdpc_pkg.sv @@
package pdpc_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH  = 3'd0,
		CFG_SCREEN_HEIGHT = 3'd1,
		CFG_PAN_X         = 3'd2,
		CFG_PAN_Y         = 3'd3,
		CFG_ZOOM_FACTOR   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        [12:0] screen_width;
		logic        [12:0] screen_height;
		logic signed [31:0] pan_x;
		logic signed [31:0] pan_y;
		logic        [31:0] zoom_factor;
	} cfg_t;

	localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd1200;
	localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd675;
	localparam logic [31:0] ZOOM_FACTOR_RST   = 32'd65536;

	// Degree biases in Q8.23: 180 and 90 degrees.
	localparam logic signed [32:0] LON_BIAS = 33'sd1509949440;
	localparam logic signed [32:0] LAT_BIAS = 33'sd754974720;

	// The floor division by 360 (or 180) is made unsigned by adding an offset that is
	// a multiple of 360; the offset quotients are removed afterwards.
	localparam logic        [31:0] DIV_OFFSET = 32'd188743680;
	localparam logic signed [24:0] DIV_BIAS_X = 25'sd524288;
	localparam logic signed [24:0] DIV_BIAS_Y = 25'sd1048576;
	// floor(2^32 / 45); the quotient estimate is at most one low.
	localparam logic        [26:0] RECIP_45   = 27'd95443717;
	localparam logic        [28:0] DIV_45     = 29'd45;

	localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

	localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

	// Zoom thresholds in Q16.16.
	localparam logic [31:0] ZOOM_1   = 32'd65536;
	localparam logic [31:0] ZOOM_5   = 32'd327680;
	localparam logic [31:0] ZOOM_10  = 32'd655360;
	localparam logic [31:0] ZOOM_20  = 32'd1310720;
	localparam logic [31:0] ZOOM_50  = 32'd3276800;
	localparam logic [31:0] ZOOM_100 = 32'd6553600;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MUL    = 7'b0000010,
		ST_RECIP  = 7'b0000100,
		ST_CORR   = 7'b0001000,
		ST_ZOOM   = 7'b0010000,
		ST_SAT    = 7'b0100000,
		ST_DECIDE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic recip;
		logic corr;
		logic zoom;
		logic sat;
		logic decide;
		logic sel_y;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	function automatic logic [6:0] step_for_zoom(input logic [31:0] z);
		logic [6:0] s;
		if (z <= ZOOM_1) s = 7'd100;
		else if (z <= ZOOM_5) s = 7'd50;
		else if (z <= ZOOM_10) s = 7'd20;
		else if (z <= ZOOM_20) s = 7'd10;
		else if (z <= ZOOM_50) s = 7'd5;
		else if (z <= ZOOM_100) s = 7'd2;
		else s = 7'd1;
		return s;
	endfunction

endpackage

@@ rtl/pdpc_ifs.sv @@
interface pdpc_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic               last_of_way;

	modport source (output valid, latitude, longitude, last_of_way, input ready);
	modport sink (input valid, latitude, longitude, last_of_way, output ready);
endinterface

interface pdpc_segment_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic        [23:0] segments_emitted;

	modport source (output valid, start_x, start_y, end_x, end_y, segments_emitted,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, segments_emitted,
		output ready);
endinterface

@@ rtl/pdpc_cfg.sv @@
module pdpc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wen,
	input  logic [pdpc_pkg::CFG_IDX_W-1:0]     index,
	input  logic [pdpc_pkg::CFG_DATA_W-1:0]    wdata,
	output pdpc_pkg::cfg_t                     cfg
);
	import pdpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= SCREEN_WIDTH_RST;
			cfg_q.screen_height <= SCREEN_HEIGHT_RST;
			cfg_q.pan_x         <= '0;
			cfg_q.pan_y         <= '0;
			cfg_q.zoom_factor   <= ZOOM_FACTOR_RST;
		end else if (wen) begin
			case (index)
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= wdata[12:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= wdata[12:0];
				CFG_PAN_X:         cfg_q.pan_x         <= $signed(wdata);
				CFG_PAN_Y:         cfg_q.pan_y         <= $signed(wdata);
				CFG_ZOOM_FACTOR:   cfg_q.zoom_factor   <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/pdpc_ctrl.sv @@
module pdpc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vtx_valid,
	output logic                   vtx_ready,
	input  pdpc_pkg::dp_status_t   status,
	output pdpc_pkg::dp_cmd_t      cmd
);
	import pdpc_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   sel_y_q;

	always_comb begin
		cmd        = '0;
		cmd.sel_y  = sel_y_q;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = vtx_valid;
				if (vtx_valid) state_next = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.recip  = 1'b1;
				state_next = ST_CORR;
			end
			ST_CORR: begin
				cmd.corr   = 1'b1;
				state_next = ST_ZOOM;
			end
			ST_ZOOM: begin
				cmd.zoom   = 1'b1;
				state_next = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat    = 1'b1;
				if (sel_y_q) state_next = ST_DECIDE;
				else state_next = ST_MUL;
			end
			ST_DECIDE: begin
				// Hold here while a previous segment still occupies the output register.
				if (status.out_free) begin
					cmd.decide = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_y_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_SAT) sel_y_q <= !sel_y_q;
		end
	end

	assign vtx_ready = (state_q == ST_IDLE);

endmodule

@@ rtl/pdpc_datapath.sv @@
module pdpc_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pdpc_pkg::cfg_t         cfg,
	input  pdpc_pkg::dp_cmd_t      cmd,
	output pdpc_pkg::dp_status_t   status,
	input  logic signed [30:0]     vtx_latitude,
	input  logic signed [31:0]     vtx_longitude,
	input  logic                   vtx_last,
	input  logic                   seg_ready,
	output logic                   seg_valid,
	output logic signed [31:0]     seg_start_x,
	output logic signed [31:0]     seg_start_y,
	output logic signed [31:0]     seg_end_x,
	output logic signed [31:0]     seg_end_y,
	output logic        [23:0]     seg_count
);
	import pdpc_pkg::*;

	function automatic logic on_screen(input logic signed [31:0] px,
		input logic signed [31:0] py, input logic [12:0] w, input logic [12:0] h);
		logic x_ok;
		logic y_ok;
		x_ok = !px[31] && ({1'b0, px[30:0]} <= {11'b0, w, 8'b0});
		y_ok = !py[31] && ({1'b0, py[30:0]} <= {11'b0, h, 8'b0});
		return x_ok && y_ok;
	endfunction

	// Captured request
	logic signed [30:0] lat_q;
	logic signed [31:0] lon_q;
	logic               last_q;

	// Projection unit, shared by x and y
	logic signed [32:0] base;
	logic        [12:0] size;
	logic signed [46:0] n_full;
	logic signed [45:0] n_s1;
	logic        [31:0] u_full;
	logic        [28:0] v;
	logic        [55:0] prod_full;
	logic        [55:0] prod_s2;
	logic        [28:0] v_s2;
	logic        [23:0] q_est;
	logic        [29:0] q45;
	logic        [28:0] rem;
	logic        [23:0] q_fix;
	logic signed [24:0] px;
	logic signed [31:0] pan;
	logic signed [33:0] d_full;
	logic signed [33:0] d_s3;
	logic signed [50:0] hi_full;
	logic signed [50:0] lo_full;
	logic signed [50:0] hi_s4;
	logic signed [50:0] lo_s4;
	logic signed [51:0] sum;
	logic signed [31:0] sat;

	// Projected vertex and polyline state
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] anchor_x_q;
	logic signed [31:0] anchor_y_q;
	logic        [6:0]  skip_q;
	logic               inside_q;
	logic        [23:0] total_q;
	logic        [7:0]  skip_inc;
	logic        [23:0] total_next;
	logic               keep;
	logic               emit;
	logic               seg_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lat_q  <= vtx_latitude;
			lon_q  <= vtx_longitude;
			last_q <= vtx_last;
		end
	end

	// Step 1: degrees offset to a nonnegative span, times the screen size.
	always_comb begin
		if (cmd.sel_y) begin
			base = LAT_BIAS - $signed({{2{lat_q[30]}}, lat_q});
			size = cfg.screen_height;
		end else begin
			base = $signed({lon_q[31], lon_q}) + LON_BIAS;
			size = cfg.screen_width;
		end
	end

	assign n_full = base * $signed({1'b0, size});

	// Step 2: floor by 2^15, offset to unsigned, then multiply by the reciprocal of 45
	// after removing the power-of-two part of 360 or 180.
	assign u_full    = {n_s1[45], n_s1[45:15]} + DIV_OFFSET;
	assign v         = cmd.sel_y ? u_full[30:2] : {1'b0, u_full[30:3]};
	assign prod_full = v * RECIP_45;

	// Step 3: correct the quotient estimate, remove the offset and subtract the pan.
	assign q_est  = prod_s2[55:32];
	assign q45    = q_est * 30'd45;
	assign rem    = v_s2 - q45[28:0];
	assign q_fix  = q_est + {23'd0, (rem >= DIV_45)};
	assign px     = $signed({1'b0, q_fix}) - (cmd.sel_y ? DIV_BIAS_Y : DIV_BIAS_X);
	assign pan    = cmd.sel_y ? cfg.pan_y : cfg.pan_x;
	assign d_full = $signed({{9{px[24]}}, px}) - $signed({{2{pan[31]}}, pan});

	// Step 4: zoom product in two halves, as integer part and fraction.
	assign hi_full = d_s3 * $signed({1'b0, cfg.zoom_factor[31:16]});
	assign lo_full = d_s3 * $signed({1'b0, cfg.zoom_factor[15:0]});

	// Step 5: combine and saturate to 32 bits.
	assign sum = $signed({hi_s4[50], hi_s4}) + $signed({{17{lo_s4[50]}}, lo_s4[50:16]});

	always_comb begin
		if ((&sum[51:31]) || !(|sum[51:31])) sat = sum[31:0];
		else if (sum[51]) sat = PIX_MIN;
		else sat = PIX_MAX;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) n_s1 <= n_full[45:0];
		if (cmd.recip) begin
			prod_s2 <= prod_full;
			v_s2    <= v;
		end
		if (cmd.corr) d_s3 <= d_full;
		if (cmd.zoom) begin
			hi_s4 <= hi_full;
			lo_s4 <= lo_full;
		end
		if (cmd.sat) begin
			if (cmd.sel_y) y_q <= sat;
			else x_q <= sat;
		end
	end

	// Decimation and culling
	assign skip_inc   = {1'b0, skip_q} + 8'd1;
	assign keep       = (skip_inc >= {1'b0, step_for_zoom(cfg.zoom_factor)}) || last_q;
	assign emit       = inside_q && keep &&
		(on_screen(anchor_x_q, anchor_y_q, cfg.screen_width, cfg.screen_height) ||
		 on_screen(x_q, y_q, cfg.screen_width, cfg.screen_height));
	assign total_next = (total_q == COUNT_MAX) ? total_q : total_q + 24'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q      <= '0;
			inside_q    <= 1'b0;
			total_q     <= '0;
			seg_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				if (!inside_q) begin
					skip_q   <= '0;
					inside_q <= !last_q;
				end else begin
					skip_q <= keep ? 7'd0 : skip_inc[6:0];
					if (last_q) inside_q <= 1'b0;
					if (emit) total_q <= total_next;
				end
			end
			if (cmd.decide && emit) seg_valid_q <= 1'b1;
			else if (seg_ready) seg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && (!inside_q || keep)) begin
			anchor_x_q <= x_q;
			anchor_y_q <= y_q;
		end
		if (cmd.decide && emit) begin
			seg_start_x <= anchor_x_q;
			seg_start_y <= anchor_y_q;
			seg_end_x   <= x_q;
			seg_end_y   <= y_q;
			seg_count   <= total_next;
		end
	end

	assign seg_valid       = seg_valid_q;
	assign status.out_free = !seg_valid_q || seg_ready;

endmodule

@@ rtl/polyline_decimate_project_cull.sv @@
// Polyline vertex projector with decimation and viewport culling. Each request on the
// vertex channel carries a Q7.23 latitude and Q8.23 longitude in degrees and a flag that
// marks the last vertex of a polyline. The vertex is projected equirectangularly to
// Q23.8 screen pixels using the configured screen size, pan and Q16.16 zoom, with
// saturation to 32 bits. The first vertex of a polyline, every step-th vertex after it
// (the step comes from the zoom thresholds) and the last vertex are kept, and a segment
// from the previously kept vertex to the new one is sent on the segment channel only
// when either end lies inside the inclusive screen rectangle, together with a
// saturating count of segments sent. A polyline of a single vertex gives nothing.
// A vertex request is accepted only in the idle state: one projection unit
// (size multiply, reciprocal multiply, correction, zoom multiply and saturation, one
// step per cycle) is used first for x and then for y, followed by the decision cycle
// and the idle cycle in which the next request is accepted.
// A finished segment waits in an output register, so the next vertex is accepted and
// projected while it waits; the decision cycle of that next vertex, whether or not it
// produces a segment, holds until the output register is free, and the vertex input
// stays closed for as long as it holds.
// Configuration registers are written through cfg_wen, cfg_index and cfg_wdata and
// must only be changed while no vertex is in flight.
module polyline_decimate_project_cull (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [pdpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	pdpc_vertex_if.sink                        vertex,
	pdpc_segment_if.source                     segment
);
	import pdpc_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Register file for screen size, pan and zoom.
	pdpc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Sequencer: walks the projection steps for x, then y, then the decision.
	pdpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vertex.valid),
		.vtx_ready (vertex.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Projection arithmetic, polyline state and the output register.
	pdpc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.vtx_latitude  (vertex.latitude),
		.vtx_longitude (vertex.longitude),
		.vtx_last      (vertex.last_of_way),
		.seg_ready     (segment.ready),
		.seg_valid     (segment.valid),
		.seg_start_x   (segment.start_x),
		.seg_start_y   (segment.start_y),
		.seg_end_x     (segment.end_x),
		.seg_end_y     (segment.end_y),
		.seg_count     (segment.segments_emitted)
	);

`ifndef SYNTHESIS
	// After a vertex is accepted, the projection keeps the input closed for a while.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.ready |=> !vertex.ready ##1 !vertex.ready)
		else $error("vertex accepted while the previous one is still being projected");

	// A segment only appears from the decision cycle, when the input is closed.
	a_segment_from_decision: assert property (@(posedge clk) disable iff (!arst_n)
		segment.valid && !$past(segment.valid) |-> !$past(vertex.ready))
		else $error("segment appeared outside the decision cycle");

	// Every segment sent carries a count of at least one.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		segment.valid |-> segment.segments_emitted != 24'd0)
		else $error("segment sent with a zero count");
`endif

endmodule
